// File: rtl/cycrep_pkg.sv
// Shared types and constants for the cyclic representative classifier.
`timescale 1ns / 1ps
`default_nettype none
package cycrep_pkg;

  localparam int unsigned MAX_SITES_DEF = 32;
  localparam int unsigned SITES_W       = 6;
  localparam int unsigned STATE_W       = 32;
  localparam int unsigned IDX_W         = 5;
  localparam int unsigned COUNT_W       = 32;

  localparam logic [SITES_W-1:0] CHAIN_LEN_RST = SITES_W'(16);

  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_READ     = 1'b1;

  typedef struct packed {
    logic load;
    logic rot_step;
    logic cnt_step;
    logic emit;
  } cycrep_cmd_t;

  typedef struct packed {
    logic rot_less;
    logic rot_eq;
    logic cnt_done;
    logic out_free;
  } cycrep_status_t;

endpackage
`default_nettype wire

// File: rtl/cycrep_if.sv
// Valid/ready channel interfaces for the input and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface cycrep_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] state_bits;
  logic [4:0]  sector_index;

  modport source (output valid, output op, output state_bits, output sector_index,
                  input ready);
  modport sink   (input valid, input op, input state_bits, input sector_index,
                  output ready);
endinterface

interface cycrep_out_if;
  logic        valid;
  logic        ready;
  logic        is_representative;
  logic [5:0]  period;
  logic [31:0] count_value;

  modport source (output valid, output is_representative, output period,
                  output count_value, input ready);
  modport sink   (input valid, input is_representative, input period,
                  input count_value, output ready);
endinterface
`default_nettype wire

// File: rtl/cycrep_ctrl.sv
// Sequencer: accept, rotate-and-compare, sector counter sweep, result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module cycrep_ctrl
  import cycrep_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_op,
  output logic                in_ready,
  input  wire cycrep_status_t status,
  output cycrep_cmd_t         cmd
);

  typedef enum logic [1:0] {S_IDLE, S_ROT, S_CNT, S_EMIT} state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_op == OP_READ) ? S_EMIT : S_ROT;
        end
      end
      S_ROT: begin
        cmd.rot_step = 1'b1;
        // a smaller rotation ends the search early, equality gives the period
        priority if (status.rot_less) begin
          state_nxt = S_EMIT;
        end else if (status.rot_eq) begin
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        cmd.cnt_step = 1'b1;
        if (status.cnt_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/cycrep_dp.sv
// Datapath: rotation register, comparator, sector counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module cycrep_dp
  import cycrep_pkg::*;
#(
  parameter int unsigned MAX_SITES = MAX_SITES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [SITES_W-1:0] cfg_wdata,
  input  wire logic               in_op,
  input  wire logic [STATE_W-1:0] in_state_bits,
  input  wire logic [IDX_W-1:0]   in_sector_index,
  input  wire cycrep_cmd_t        cmd,
  output cycrep_status_t          status,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    out_is_representative,
  output logic [SITES_W-1:0]      out_period,
  output logic [COUNT_W-1:0]      out_count_value
);

  localparam int unsigned KW = $clog2(MAX_SITES);
  localparam logic [SITES_W-1:0] MAX_N = SITES_W'(MAX_SITES);

  logic [SITES_W-1:0]   chain_len_r;
  logic [SITES_W-1:0]   n_r, n_nxt;
  logic [MAX_SITES-1:0] mask_nxt, mask_r;
  logic [MAX_SITES-1:0] s_r, r_r, rot;
  logic [SITES_W-1:0]   step_r;
  logic [SITES_W-1:0]   period_r;
  logic                 rep_r;
  logic                 op_r;
  logic [IDX_W-1:0]     idx_r;
  logic [KW-1:0]        k_r;
  logic [SITES_W-1:0]   acc_r;
  logic [SITES_W:0]     acc_sum;
  logic [COUNT_W-1:0]   cnt_r [MAX_SITES];
  logic [COUNT_W-1:0]   rd_count;
  logic                 out_valid_r;
  logic                 out_rep_r;
  logic [SITES_W-1:0]   out_period_r;
  logic [COUNT_W-1:0]   out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_len_r <= CHAIN_LEN_RST;
    end else if (cfg_we) begin
      chain_len_r <= cfg_wdata;
    end
  end

  // zero sites acts as one, anything past the array depth is clamped
  always_comb begin
    priority if (chain_len_r == '0) begin
      n_nxt = SITES_W'(1);
    end else if (chain_len_r > MAX_N) begin
      n_nxt = MAX_N;
    end else begin
      n_nxt = chain_len_r;
    end
    for (int j = 0; j < MAX_SITES; j++) begin
      mask_nxt[j] = (SITES_W'(j) < n_nxt);
    end
  end

  // rotate left by one inside the n low sites
  always_comb begin
    for (int j = 0; j < MAX_SITES; j++) begin
      if (j == 0) begin
        rot[j] = r_r[KW'(n_r - SITES_W'(1))];
      end else begin
        rot[j] = r_r[j-1] & mask_r[j];
      end
    end
  end

  assign acc_sum = {1'b0, acc_r} + {1'b0, period_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r      <= n_nxt;
      mask_r   <= mask_nxt;
      s_r      <= in_state_bits[MAX_SITES-1:0] & mask_nxt;
      r_r      <= in_state_bits[MAX_SITES-1:0] & mask_nxt;
      step_r   <= SITES_W'(1);
      period_r <= '0;
      rep_r    <= 1'b0;
      op_r     <= in_op;
      idx_r    <= in_sector_index;
      k_r      <= '0;
      acc_r    <= '0;
    end
    if (cmd.rot_step) begin
      r_r    <= rot;
      step_r <= step_r + SITES_W'(1);
      if (!status.rot_less && status.rot_eq) begin
        period_r <= step_r;
        rep_r    <= 1'b1;
      end
    end
    if (cmd.cnt_step) begin
      k_r <= k_r + KW'(1);
      // running value of period*k mod n; sum stays below 2n
      if (acc_sum >= {1'b0, n_r}) begin
        acc_r <= SITES_W'(acc_sum - {1'b0, n_r});
      end else begin
        acc_r <= acc_sum[SITES_W-1:0];
      end
    end
  end

  // one saturating counter per sector, bumped when its k divides cleanly
  for (genvar e = 0; e < MAX_SITES; e++) begin : g_cnt
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r[e] <= '0;
      end else if (cmd.cnt_step && acc_r == '0 && k_r == KW'(e) && cnt_r[e] != '1) begin
        cnt_r[e] <= cnt_r[e] + COUNT_W'(1);
      end
    end
  end

  always_comb begin
    if ({1'b0, idx_r} < (IDX_W + 1)'(MAX_SITES)) begin
      rd_count = cnt_r[idx_r[KW-1:0]];
    end else begin
      rd_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (op_r == OP_READ) begin
        out_rep_r    <= 1'b0;
        out_period_r <= '0;
        out_count_r  <= rd_count;
      end else begin
        out_rep_r    <= rep_r;
        out_period_r <= period_r;
        out_count_r  <= '0;
      end
    end
  end

  assign status.rot_less = (rot < s_r);
  assign status.rot_eq   = (rot == s_r);
  assign status.cnt_done = (SITES_W'(k_r) == n_r - SITES_W'(1));
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid             = out_valid_r;
  assign out_is_representative = out_rep_r;
  assign out_period            = out_period_r;
  assign out_count_value       = out_count_r;

endmodule
`default_nettype wire

// File: rtl/cyclic_representative_classifier.sv
// Flow: a read is loaded and goes straight to the emit state; a classify takes r
// rotations (1..n) until a smaller or equal rotation, then c = n sector counter
// updates for a representative (0 otherwise), n = chain_length, before the emit state.
// One item at a time: a new input beat is accepted only in the idle state, after the
// previous result is emitted; one rotate/compare unit, one-sector-per-cycle update sweep.
// Reset (rst_n, synchronous): sector counters cleared, chain_length back to 16.
`timescale 1ns / 1ps
`default_nettype none
module cyclic_representative_classifier
  import cycrep_pkg::*;
#(
  parameter int unsigned MAX_SITES = MAX_SITES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [SITES_W-1:0] cfg_wdata,
  cycrep_in_if.sink               in_ch,
  cycrep_out_if.source            out_ch
);

  cycrep_cmd_t    cmd;
  cycrep_status_t status;
  logic           in_ready;

  cycrep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cycrep_dp #(
    .MAX_SITES (MAX_SITES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_op                 (in_ch.op),
    .in_state_bits         (in_ch.state_bits),
    .in_sector_index       (in_ch.sector_index),
    .cmd                   (cmd),
    .status                (status),
    .out_ready             (out_ch.ready),
    .out_valid             (out_ch.valid),
    .out_is_representative (out_ch.is_representative),
    .out_period            (out_ch.period),
    .out_count_value       (out_ch.count_value)
  );

  assign in_ch.ready = in_ready;

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result loaded while previous beat still pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("new beat accepted while item in progress");

  a_rep_period: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.is_representative) |->
      (out_ch.period != '0 && out_ch.count_value == '0))
    else $error("representative result without period");

  a_nonrep_period: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.is_representative) |-> out_ch.period == '0)
    else $error("period reported for a non-representative");
`endif

endmodule
`default_nettype wire
